/* hdl/limit_order_book_matcher_assert.svh */
// assertion macros for the order book matcher checker
// depends on nothing; the including module provides clk_i and rst_ni
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LOBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LOBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lobm_pkg.sv */
// shared types and constants of the order book matcher
// depends on nothing
package lobm_pkg;

  localparam int unsigned MAX_ORDERS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_LIMIT  = 2'd0,
    CMD_MARKET = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_RESTING  = 3'd0,
    STAT_PARTIAL  = 3'd1,
    STAT_FILLED   = 3'd2,
    STAT_CANCELED = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_REJECTED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_TRADE,
    S_DECIDE,
    S_SCAN,
    S_CDONE
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        side;
    logic [31:0] ord_id;
    logic [31:0] price;
    logic [23:0] quantity;
    logic [47:0] stamp;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] trade_price;
    logic [23:0] deal_qty;
    logic [47:0] trade_time;
    logic [2:0]  status;
    logic [23:0] filled;
    logic [28:0] bid_total;
    logic [28:0] ask_total;
    logic        last;
  } res_t;

  // payload of one resting order
  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [23:0] rem;
    logic [31:0] id;
    logic [47:0] stamp;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic        ins;
    logic        del;
    logic        upd;
    logic [23:0] upd_rem;
  } cell_ctl_t;

endpackage

/* hdl/lobm_cell.sv */
// one book slot: holds an order and shifts to its neighbors on insert or removal
// depends on lobm_pkg
module lobm_cell import lobm_pkg::*; #(
  parameter int unsigned MaxOrders = MAX_ORDERS_DEF,
  parameter int unsigned CellIdx   = 0,
  localparam int unsigned IdxW     = $clog2(MaxOrders)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  entry_t          new_i,
  input  logic [IdxW-1:0] new_rank_i,
  input  logic [IdxW-1:0] tgt_idx_i,
  input  logic [IdxW-1:0] rank_thr_i,
  input  logic            left_valid_i,
  input  entry_t          left_entry_i,
  input  logic [IdxW-1:0] left_rank_i,
  input  logic            left_before_i,
  input  logic            right_valid_i,
  input  entry_t          right_entry_i,
  input  logic [IdxW-1:0] right_rank_i,
  output logic            valid_o,
  output entry_t          entry_o,
  output logic [IdxW-1:0] rank_o,
  output logic            before_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic            valid_q, valid_d;
  entry_t          ent_q, ent_d;
  logic [IdxW-1:0] rank_q, rank_d;
  logic [32:0]     key_new, key_own;

  // sells first by rising price, then buys by falling price
  assign key_new  = {~new_i.side, new_i.side ? new_i.price : ~new_i.price};
  assign key_own  = {~ent_q.side, ent_q.side ? ent_q.price : ~ent_q.price};
  assign before_o = valid_q & ~(key_new < key_own);

  // next slot content
  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    rank_d  = rank_q;
    if (ctl_i.ins) begin
      if (!before_o) begin
        if (left_before_i) begin
          valid_d = 1'b1;
          ent_d   = new_i;
          rank_d  = new_rank_i;
        end else begin
          valid_d = left_valid_i;
          ent_d   = left_entry_i;
          rank_d  = left_rank_i;
        end
      end
    end else if (ctl_i.del) begin
      if (MyIdx >= tgt_idx_i) begin
        valid_d = right_valid_i;
        ent_d   = right_entry_i;
        rank_d  = right_rank_i;
      end
      if (rank_d > rank_thr_i) begin
        rank_d = rank_d - 1'b1;
      end
    end else if (ctl_i.upd && MyIdx == tgt_idx_i) begin
      ent_d.rem = ctl_i.upd_rem;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // order payload
  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    rank_q <= rank_d;
  end

  assign valid_o = valid_q;
  assign entry_o = ent_q;
  assign rank_o  = rank_q;

endmodule

/* hdl/limit_order_book_matcher.sv */
// top level of the price-time priority order book matcher
// depends on lobm_pkg and lobm_cell
//
// usage: drive req_i and raise start; a request is taken at an edge where
// start is high and busy is low. results appear on res_o for one cycle each,
// marked by valid_o: zero or more trades, then one report with last set.
// the book is a row of MaxOrders cells kept sorted by price then arrival,
// with sells ahead of buys; inserts and removals shift cells by one.
// steps after the accepting edge: each trade is a fetch of the best opposite
// order, then the trade. an order filled by its trades reports after the last
// trade; one that rests, is cancelled or is rejected reports after a last
// fetch that finds no cross; a zero quantity order goes straight to its report.
// a cancel scans every cell one per cycle, then reports.
// the next request can be taken at the edge that ends the report cycle.
// an unused command is taken and dropped with no results.
// reset empties the book and clears both totals at once; no sweep is needed.
// results cannot be held off by the receiver, so none are ever stalled.
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int unsigned MaxOrders = MAX_ORDERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);

  localparam int unsigned IdxW = $clog2(MaxOrders);
  localparam int unsigned CntW = $clog2(MaxOrders + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MaxOrders);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxOrders - 1);

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [23:0]     left_q, left_d, filled_q, filled_d;
  entry_t          cand_q, cand_d;
  logic            cand_ok_q, cand_ok_d;
  logic [IdxW-1:0] cand_rank_q, cand_rank_d, cidx_q, cidx_d;
  logic [CntW-1:0] count_q, count_d, nsell_q, nsell_d;
  logic [28:0]     bsum_q, bsum_d, ssum_q, ssum_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic            hit_q, hit_d, hside_q, hside_d;
  logic [IdxW-1:0] hidx_q, hidx_d, hrank_q, hrank_d;
  logic [23:0]     hrem_q, hrem_d;
  res_t            res_q, res_d;
  logic            rv_q, rv_d;

  cell_ctl_t       ctl;
  entry_t          new_ent;
  logic [IdxW-1:0] tgt_idx, rank_thr, rd_idx;
  logic            fetch_ok, crosses;
  logic [23:0]     tq;

  logic            c_valid  [MaxOrders];
  entry_t          c_ent    [MaxOrders];
  logic [IdxW-1:0] c_rank   [MaxOrders];
  logic            c_before [MaxOrders];

  // row of cells, each wired to its neighbors
  for (genvar g = 0; g < MaxOrders; g++) begin : g_cell
    logic            lv, lb, rv;
    entry_t          le, re;
    logic [IdxW-1:0] lr, rr;
    if (g == 0) begin : g_head
      assign lv = 1'b0;
      assign le = '0;
      assign lr = '0;
      assign lb = 1'b1;
    end else begin : g_mid
      assign lv = c_valid[g-1];
      assign le = c_ent[g-1];
      assign lr = c_rank[g-1];
      assign lb = c_before[g-1];
    end
    if (g == MaxOrders - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
      assign rr = '0;
    end else begin : g_body
      assign rv = c_valid[g+1];
      assign re = c_ent[g+1];
      assign rr = c_rank[g+1];
    end
    lobm_cell #(.MaxOrders(MaxOrders), .CellIdx(g)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_i         (new_ent),
      .new_rank_i    (count_q[IdxW-1:0]),
      .tgt_idx_i     (tgt_idx),
      .rank_thr_i    (rank_thr),
      .left_valid_i  (lv),
      .left_entry_i  (le),
      .left_rank_i   (lr),
      .left_before_i (lb),
      .right_valid_i (rv),
      .right_entry_i (re),
      .right_rank_i  (rr),
      .valid_o       (c_valid[g]),
      .entry_o       (c_ent[g]),
      .rank_o        (c_rank[g]),
      .before_o      (c_before[g])
    );
  end

  // single read port into the row: scan cursor or best opposite order
  assign fetch_ok = ~req_q.side | (nsell_q < FullCnt);
  assign rd_idx   = (state_q == S_SCAN) ? cur_q
                  : (req_q.side ? nsell_q[IdxW-1:0] : '0);
  assign new_ent  = '{side: req_q.side, price: req_q.price, rem: left_q,
                      id: req_q.ord_id, stamp: req_q.stamp};
  assign crosses  = (req_q.cmd == CMD_MARKET) ||
                    (req_q.side ? (cand_q.price >= req_q.price)
                                : (cand_q.price <= req_q.price));
  assign tq       = (left_q < cand_q.rem) ? left_q : cand_q.rem;

  // sequencer: next state, book commands and results
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    left_d      = left_q;
    filled_d    = filled_q;
    cand_d      = cand_q;
    cand_ok_d   = cand_ok_q;
    cand_rank_d = cand_rank_q;
    cidx_d      = cidx_q;
    count_d     = count_q;
    nsell_d     = nsell_q;
    bsum_d      = bsum_q;
    ssum_d      = ssum_q;
    cur_d       = cur_q;
    hit_d       = hit_q;
    hside_d     = hside_q;
    hidx_d      = hidx_q;
    hrank_d     = hrank_q;
    hrem_d      = hrem_q;
    res_d       = '0;
    rv_d        = 1'b0;
    ctl         = '0;
    tgt_idx     = cidx_q;
    rank_thr    = cand_rank_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d    = req_i;
          left_d   = req_i.quantity;
          filled_d = '0;
          cur_d    = '0;
          hit_d    = 1'b0;
          priority if (req_i.cmd == CMD_NONE) begin
            state_d = S_IDLE;
          end else if (req_i.cmd == CMD_CANCEL) begin
            state_d = S_SCAN;
          end else if (req_i.quantity == '0) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cand_d      = c_ent[rd_idx];
        cand_rank_d = c_rank[rd_idx];
        cand_ok_d   = fetch_ok & c_valid[rd_idx] & (c_ent[rd_idx].side != req_q.side);
        cidx_d      = rd_idx;
        state_d     = S_TRADE;
      end
      S_TRADE: begin
        if (cand_ok_q && crosses) begin
          rv_d              = 1'b1;
          res_d.kind        = 1'b0;
          res_d.buy_id      = req_q.side ? cand_q.id : req_q.ord_id;
          res_d.sell_id     = req_q.side ? req_q.ord_id : cand_q.id;
          res_d.trade_price = cand_q.price;
          res_d.deal_qty    = tq;
          res_d.trade_time  = (req_q.stamp > cand_q.stamp) ? req_q.stamp : cand_q.stamp;
          left_d            = left_q - tq;
          filled_d          = filled_q + tq;
          if (cand_q.side) begin
            ssum_d = ssum_q - 29'(tq);
          end else begin
            bsum_d = bsum_q - 29'(tq);
          end
          if (cand_q.rem == tq) begin
            ctl.del = 1'b1;
            count_d = count_q - 1'b1;
            if (cand_q.side) begin
              nsell_d = nsell_q - 1'b1;
            end
          end else begin
            ctl.upd     = 1'b1;
            ctl.upd_rem = cand_q.rem - tq;
          end
          state_d = (left_d == '0) ? S_DECIDE : S_FETCH;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rv_d         = 1'b1;
        res_d.kind   = 1'b1;
        res_d.last   = 1'b1;
        res_d.filled = filled_q;
        priority if (left_q == '0) begin
          res_d.status = STAT_FILLED;
        end else if (req_q.cmd == CMD_MARKET) begin
          res_d.status = STAT_CANCELED;
        end else if (count_q == FullCnt) begin
          res_d.status = STAT_REJECTED;
        end else begin
          ctl.ins = 1'b1;
          count_d = count_q + 1'b1;
          if (req_q.side) begin
            nsell_d = nsell_q + 1'b1;
            ssum_d  = ssum_q + 29'(left_q);
          end else begin
            bsum_d  = bsum_q + 29'(left_q);
          end
          res_d.status = (filled_q != '0) ? STAT_PARTIAL : STAT_RESTING;
        end
        res_d.bid_total = bsum_d;
        res_d.ask_total = ssum_d;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (c_valid[rd_idx] && c_ent[rd_idx].id == req_q.ord_id &&
            (!hit_q || c_rank[rd_idx] < hrank_q)) begin
          hit_d   = 1'b1;
          hidx_d  = rd_idx;
          hrank_d = c_rank[rd_idx];
          hside_d = c_ent[rd_idx].side;
          hrem_d  = c_ent[rd_idx].rem;
        end
        cur_d   = cur_q + 1'b1;
        state_d = (cur_q == LastIdx) ? S_CDONE : S_SCAN;
      end
      S_CDONE: begin
        tgt_idx      = hidx_q;
        rank_thr     = hrank_q;
        rv_d         = 1'b1;
        res_d.kind   = 1'b1;
        res_d.last   = 1'b1;
        res_d.status = STAT_NOTFOUND;
        if (hit_q) begin
          ctl.del      = 1'b1;
          count_d      = count_q - 1'b1;
          res_d.status = STAT_CANCELED;
          if (hside_q) begin
            nsell_d = nsell_q - 1'b1;
            ssum_d  = ssum_q - 29'(hrem_q);
          end else begin
            bsum_d  = bsum_q - 29'(hrem_q);
          end
        end
        res_d.bid_total = bsum_d;
        res_d.ask_total = ssum_d;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      nsell_q <= '0;
      bsum_q  <= '0;
      ssum_q  <= '0;
      rv_q    <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      nsell_q <= nsell_d;
      bsum_q  <= bsum_d;
      ssum_q  <= ssum_d;
      rv_q    <= rv_d;
      hit_q   <= hit_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    left_q      <= left_d;
    filled_q    <= filled_d;
    cand_q      <= cand_d;
    cand_ok_q   <= cand_ok_d;
    cand_rank_q <= cand_rank_d;
    cidx_q      <= cidx_d;
    cur_q       <= cur_d;
    hside_q     <= hside_d;
    hidx_q      <= hidx_d;
    hrank_q     <= hrank_d;
    hrem_q      <= hrem_d;
    res_q       <= res_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = rv_q;
  assign res_o   = res_q;

endmodule

/* hdl/lobm_checker.sv */
// port-level checker for the order book matcher, bound to the top level
// depends on lobm_pkg and limit_order_book_matcher_assert.svh
`include "limit_order_book_matcher_assert.svh"
module lobm_checker import lobm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input req_t req_i,
  input logic busy,
  input logic valid_o,
  input res_t res_o
);

  // a trade is never the end of a request, so work goes on
  `LOBM_ASSERT_NOW(a_trade_busy, valid_o && !res_o.last, busy, "trade without busy")
  // trades carry a nonzero quantity and no last flag
  `LOBM_ASSERT_NOW(a_trade_form, valid_o && !res_o.kind, !res_o.last && res_o.deal_qty != '0, "bad trade")
  // the report frees the block
  `LOBM_ASSERT_NOW(a_report_idle, valid_o && res_o.last, !busy && res_o.kind, "report while busy")
  // a real command keeps the block busy after it is taken
  `LOBM_ASSERT_NEXT(a_take_busy, start && !busy && req_i.cmd != CMD_NONE, busy, "command dropped")

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);

/* tb/sv/tb_limit_order_book_matcher.sv */
// self-checking testbench of the price-time priority order book matcher
// depends on lobm_pkg and the limit_order_book_matcher rtl
module tb_limit_order_book_matcher;
  import lobm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = MAX_ORDERS_DEF;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned RandItems = 260;

  // expected book contents and the trades and reports they produce
  class book_scoreboard;
    bit              live[Depth];
    logic            o_side[Depth];
    logic [31:0]     o_price[Depth];
    logic [23:0]     o_rem[Depth];
    logic [31:0]     o_id[Depth];
    logic [47:0]     o_stamp[Depth];
    longint unsigned o_seq[Depth];
    logic [28:0]     bid_sum;
    logic [28:0]     ask_sum;
    longint unsigned arrivals;
    res_t            awaited[$];
    int              errors;

    function new();
      foreach (live[i]) live[i] = 0;
      bid_sum = '0;
      ask_sum = '0;
      arrivals = 0;
      errors = 0;
    endfunction

    // best resting order of one side, -1 when that side is empty
    function int best_of(logic want);
      int b;
      b = -1;
      for (int i = 0; i < Depth; i++) begin
        if (!live[i] || o_side[i] != want) continue;
        if (b < 0) b = i;
        else if (o_price[i] != o_price[b]) begin
          if (want ? (o_price[i] < o_price[b]) : (o_price[i] > o_price[b])) b = i;
        end else if (o_seq[i] < o_seq[b]) b = i;
      end
      return b;
    endfunction

    function void push_report(status_e st, logic [23:0] fl);
      res_t r;
      r = '0;
      r.kind = 1'b1;
      r.status = st;
      r.filled = fl;
      r.bid_total = bid_sum;
      r.ask_total = ask_sum;
      r.last = 1'b1;
      awaited.push_front(r);
    endfunction

    // work out every result of one accepted request
    function void note(req_t q);
      logic [23:0] left, fl, t;
      int b, hit, f;
      res_t r;
      left = q.quantity;
      fl = '0;
      if (q.cmd == CMD_NONE) return;
      if (q.cmd == CMD_CANCEL) begin
        hit = -1;
        for (int i = 0; i < Depth; i++)
          if (live[i] && o_id[i] == q.ord_id && (hit < 0 || o_seq[i] < o_seq[hit]))
            hit = i;
        if (hit >= 0) begin
          if (o_side[hit]) ask_sum = ask_sum - 29'(o_rem[hit]);
          else bid_sum = bid_sum - 29'(o_rem[hit]);
          live[hit] = 0;
          push_report(STAT_CANCELED, '0);
        end else push_report(STAT_NOTFOUND, '0);
        return;
      end
      // sweep the opposite side
      while (left != 0) begin
        b = best_of(~q.side);
        if (b < 0) break;
        if (q.cmd == CMD_LIMIT) begin
          if (!q.side && o_price[b] > q.price) break;
          if (q.side && o_price[b] < q.price) break;
        end
        t = (left < o_rem[b]) ? left : o_rem[b];
        r = '0;
        r.buy_id = q.side ? o_id[b] : q.ord_id;
        r.sell_id = q.side ? q.ord_id : o_id[b];
        r.trade_price = o_price[b];
        r.deal_qty = t;
        r.trade_time = (q.stamp > o_stamp[b]) ? q.stamp : o_stamp[b];
        awaited.push_front(r);
        left = left - t;
        fl = fl + t;
        o_rem[b] = o_rem[b] - t;
        if (o_side[b]) ask_sum = ask_sum - 29'(t);
        else bid_sum = bid_sum - 29'(t);
        if (o_rem[b] == 0) live[b] = 0;
      end
      if (left == 0) push_report(STAT_FILLED, fl);
      else if (q.cmd == CMD_MARKET) push_report(STAT_CANCELED, fl);
      else begin
        f = -1;
        for (int i = 0; i < Depth; i++)
          if (!live[i] && f < 0) f = i;
        if (f < 0) push_report(STAT_REJECTED, fl);
        else begin
          live[f] = 1;
          o_side[f] = q.side;
          o_price[f] = q.price;
          o_rem[f] = left;
          o_id[f] = q.ord_id;
          o_stamp[f] = q.stamp;
          o_seq[f] = arrivals;
          arrivals++;
          if (q.side) ask_sum = ask_sum + 29'(left);
          else bid_sum = bid_sum + 29'(left);
          push_report((fl != 0) ? STAT_PARTIAL : STAT_RESTING, fl);
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one result with the oldest expectation
    task check(res_t got);
      res_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = awaited.pop_back();
      if (got.kind !== e.kind) report($sformatf("kind %h exp %h", got.kind, e.kind));
      if (got.buy_id !== e.buy_id)
        report($sformatf("buy_id %h exp %h", got.buy_id, e.buy_id));
      if (got.sell_id !== e.sell_id)
        report($sformatf("sell_id %h exp %h", got.sell_id, e.sell_id));
      if (got.trade_price !== e.trade_price)
        report($sformatf("trade_price %h exp %h", got.trade_price, e.trade_price));
      if (got.deal_qty !== e.deal_qty)
        report($sformatf("deal_qty %h exp %h", got.deal_qty, e.deal_qty));
      if (got.trade_time !== e.trade_time)
        report($sformatf("trade_time %h exp %h", got.trade_time, e.trade_time));
      if (got.status !== e.status)
        report($sformatf("status %h exp %h", got.status, e.status));
      if (got.filled !== e.filled)
        report($sformatf("filled %h exp %h", got.filled, e.filled));
      if (got.bid_total !== e.bid_total)
        report($sformatf("bid_total %h exp %h", got.bid_total, e.bid_total));
      if (got.ask_total !== e.ask_total)
        report($sformatf("ask_total %h exp %h", got.ask_total, e.ask_total));
      if (got.last !== e.last) report($sformatf("last %h exp %h", got.last, e.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic valid_o;
  res_t res_o;

  book_scoreboard sb;
  int unsigned idle_pct;
  int unsigned quiet;
  logic [31:0] id_pool[16];

  limit_order_book_matcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // result monitor and watchdog on quiet cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check(res_o);
      if (valid_o || (start && !busy)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one request: optional idle gap, then hold start until taken
  task send_req(req_t q);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = q;
    do @(posedge clk_i); while (busy);
    sb.note(q);
  endtask

  function req_t mk(cmd_e c, logic sd, logic [31:0] id, logic [31:0] p,
                    logic [23:0] qty, logic [47:0] st);
    req_t q;
    q.cmd = c;
    q.side = sd;
    q.ord_id = id;
    q.price = p;
    q.quantity = qty;
    q.stamp = st;
    return q;
  endfunction

  // random request, mostly orders near one price with pooled ids
  function req_t rand_req();
    req_t q;
    int unsigned k;
    q.stamp = 48'({$urandom, $urandom});
    q.side = 1'($urandom_range(1));
    q.ord_id = ($urandom_range(3) == 0) ? $urandom : id_pool[$urandom_range(15)];
    q.price = ($urandom_range(15) == 0) ? $urandom : 32'd1000 + $urandom_range(8);
    k = $urandom_range(19);
    q.quantity = (k == 0) ? 24'd0 : (k == 1) ? 24'($urandom) : (k == 2) ? 24'hffffff
               : 24'($urandom_range(40, 1));
    k = $urandom_range(99);
    q.cmd = (k < 55) ? CMD_LIMIT : (k < 75) ? CMD_MARKET : (k < 97) ? CMD_CANCEL : CMD_NONE;
    return q;
  endfunction

  initial begin
    sb = new();
    quiet = 0;
    idle_pct = 0;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    foreach (id_pool[i]) id_pool[i] = (i == 15) ? 32'hffffffff : $urandom;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero size, unused command, cancel on empty book
    send_req(mk(CMD_LIMIT, 1'b0, 32'd1, 32'd50, 24'd0, 48'd1));
    send_req(mk(CMD_NONE, 1'b1, 32'd2, 32'd50, 24'd5, 48'd2));
    send_req(mk(CMD_CANCEL, 1'b0, 32'd3, 32'd0, 24'd0, 48'd3));
    // resting, crossing, market remainder and full market fill
    send_req(mk(CMD_LIMIT, 1'b0, 32'd10, 32'd100, 24'd5, 48'hffffffffffff));
    send_req(mk(CMD_LIMIT, 1'b1, 32'd11, 32'd99, 24'd8, 48'd5));
    send_req(mk(CMD_MARKET, 1'b0, 32'd12, 32'd0, 24'd10, 48'd6));
    send_req(mk(CMD_LIMIT, 1'b1, 32'd13, 32'hffffffff, 24'd4, 48'd7));
    send_req(mk(CMD_MARKET, 1'b0, 32'd14, 32'd0, 24'd4, 48'd8));
    send_req(mk(CMD_MARKET, 1'b1, 32'd15, 32'd0, 24'd4, 48'd9));
    // duplicate ids: the earlier one is cancelled
    send_req(mk(CMD_LIMIT, 1'b0, 32'd20, 32'd7, 24'd3, 48'd10));
    send_req(mk(CMD_LIMIT, 1'b0, 32'd20, 32'd8, 24'd6, 48'd11));
    send_req(mk(CMD_CANCEL, 1'b1, 32'd20, 32'd0, 24'd0, 48'd12));
    send_req(mk(CMD_CANCEL, 1'b0, 32'd20, 32'd0, 24'd0, 48'd13));
    // full book, a rejected remainder, then full-size sells against the best buy
    for (int i = 0; i < Depth; i++)
      send_req(mk(CMD_LIMIT, 1'b0, 32'd100 + i, 32'(i % 5), 24'hffffff, 48'(i)));
    send_req(mk(CMD_LIMIT, 1'b0, 32'd200, 32'd1, 24'd9, 48'd99));
    send_req(mk(CMD_LIMIT, 1'b1, 32'd201, 32'd0, 24'hffffff, 48'd100));
    send_req(mk(CMD_LIMIT, 1'b0, 32'd202, 32'd0, 24'd1, 48'd101));
    send_req(mk(CMD_MARKET, 1'b1, 32'hffffffff, 32'hffffffff, 24'hffffff, 48'd102));
    send_req(mk(CMD_MARKET, 1'b1, 32'd203, 32'd0, 24'd0, 48'd103));

    // random phases, two of them with sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 67 : (ph == 2) ? 24 : 0;
      for (int n = 0; n < RandItems / 4; n++) send_req(rand_req());
    end

    @(negedge clk_i);
    start = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
    if (sb.awaited.size() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/lobm_pkg.sv
hdl/lobm_cell.sv
hdl/limit_order_book_matcher.sv
hdl/lobm_checker.sv
tb/sv/tb_limit_order_book_matcher.sv
